[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR  = 16'hFFFD;
    localparam logic [15:0] SURR_HIGH  = 16'hD800;
    localparam logic [15:0] SURR_LOW   = 16'hDC00;
    localparam logic [20:0] SURR_FIRST = 21'h00D800;
    localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam int          MAX_UNITS  = 4;

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_SEQ,
        LEAD_BAD
    } lead_class_t;

    typedef struct packed {
        logic [2:0]                      count;
        logic [MAX_UNITS-1:0][15:0]      unit;
        logic [MAX_UNITS-1:0]            repl;
        logic                            last;
    } bundle_t;

endpackage

`default_nettype wire

[rtl/u8u16_dec.sv]
// Sequence state and per-byte decode into a bundle of UTF-16 code units.
`default_nettype none

module u8u16_dec (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic                stream_last,
    output u8u16_pkg::bundle_t       bundle
);

    logic [7:0] lead_byte_reg, lead_byte_next;
    logic [1:0] needed_reg, needed_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] merged;

    u8u16_pkg::lead_class_t lead_class;
    logic [1:0]  lead_need;
    logic        lead_emit;
    logic [15:0] lead_unit;
    logic        lead_repl;
    logic        lead_open;
    logic        is_cont;
    logic [1:0]  h;
    logic [2:0]  h1;
    logic [2:0]  k;
    logic [20:0] cp;
    logic [19:0] cp_off;
    logic        cp_ok;

    always_comb
    begin
        lead_need = 2'd0;
        if (!in_byte[7])
        begin
            lead_class = u8u16_pkg::LEAD_ASCII;
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            lead_class = u8u16_pkg::LEAD_SEQ;
            lead_need  = 2'd1;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_class = u8u16_pkg::LEAD_SEQ;
            lead_need  = 2'd2;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_class = u8u16_pkg::LEAD_SEQ;
            lead_need  = 2'd3;
        end
        else
        begin
            lead_class = u8u16_pkg::LEAD_BAD;
        end
    end

    always_comb
    begin
        lead_emit = 1'b1;
        lead_unit = u8u16_pkg::REPL_CHAR;
        lead_repl = 1'b1;
        lead_open = 1'b0;
        case (lead_class)
            u8u16_pkg::LEAD_ASCII:
            begin
                lead_unit = {8'h00, in_byte};
                lead_repl = 1'b0;
            end
            u8u16_pkg::LEAD_SEQ:
            begin
                if (!stream_last)
                begin
                    lead_emit = 1'b0;
                    lead_open = 1'b1;
                end
            end
            default:
            begin
                lead_emit = 1'b1;
            end
        endcase
    end

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign h       = (held_count_reg == 2'd3) ? 2'd2 : held_count_reg;
    assign h1      = {1'b0, h} + 3'd1;
    assign k       = {1'b0, held_count_reg} + 3'd1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            merged[i] = (2'(i) == h) ? in_byte : held_reg[i];
        end
    end

    always_comb
    begin
        cp    = '0;
        cp_ok = 1'b0;
        case (needed_reg)
            2'd1:
            begin
                cp    = {10'd0, lead_byte_reg[4:0], merged[0][5:0]};
                cp_ok = (cp >= u8u16_pkg::MIN_TWO);
            end
            2'd2:
            begin
                cp    = {5'd0, lead_byte_reg[3:0], merged[0][5:0], merged[1][5:0]};
                cp_ok = (cp >= u8u16_pkg::MIN_THREE)
                        && !((cp >= u8u16_pkg::SURR_FIRST) && (cp <= u8u16_pkg::SURR_LAST));
            end
            default:
            begin
                cp    = {lead_byte_reg[2:0], merged[0][5:0], merged[1][5:0], merged[2][5:0]};
                cp_ok = (cp >= u8u16_pkg::MIN_FOUR) && (cp <= u8u16_pkg::MAX_SCALAR);
            end
        endcase
    end

    assign cp_off = 20'(cp - u8u16_pkg::MIN_FOUR);

    always_comb
    begin
        lead_byte_next  = lead_byte_reg;
        needed_next     = needed_reg;
        held_count_next = held_count_reg;
        bundle.count    = 3'd0;
        bundle.last     = stream_last;
        for (int i = 0; i < u8u16_pkg::MAX_UNITS; i++)
        begin
            bundle.unit[i] = u8u16_pkg::REPL_CHAR;
            bundle.repl[i] = 1'b1;
        end

        if (needed_reg != 2'd0 && is_cont)
        begin
            held_count_next = h1[1:0];
            if (h1 >= {1'b0, needed_reg})
            begin
                needed_next     = 2'd0;
                held_count_next = 2'd0;
                if (!cp_ok)
                begin
                    bundle.count = {1'b0, needed_reg} + 3'd1;
                end
                else if (cp[20:16] == 5'd0)
                begin
                    bundle.count   = 3'd1;
                    bundle.unit[0] = cp[15:0];
                    bundle.repl[0] = 1'b0;
                end
                else
                begin
                    bundle.count   = 3'd2;
                    bundle.unit[0] = u8u16_pkg::SURR_HIGH | {6'd0, cp_off[19:10]};
                    bundle.unit[1] = u8u16_pkg::SURR_LOW  | {6'd0, cp_off[9:0]};
                    bundle.repl[0] = 1'b0;
                    bundle.repl[1] = 1'b0;
                end
            end
            else if (stream_last)
            begin
                needed_next     = 2'd0;
                held_count_next = 2'd0;
                bundle.count    = h1 + 3'd1;
            end
        end
        else
        begin
            if (needed_reg != 2'd0)
            begin
                bundle.count = k;
            end
            needed_next     = 2'd0;
            held_count_next = 2'd0;
            if (lead_emit)
            begin
                for (int i = 0; i < u8u16_pkg::MAX_UNITS; i++)
                begin
                    if ((needed_reg == 2'd0 && i == 0)
                        || (needed_reg != 2'd0 && 3'(i) == k))
                    begin
                        bundle.unit[i] = lead_unit;
                        bundle.repl[i] = lead_repl;
                    end
                end
                bundle.count = (needed_reg != 2'd0) ? k + 3'd1 : 3'd1;
            end
            if (lead_open)
            begin
                lead_byte_next = in_byte;
                needed_next    = lead_need;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_byte_reg  <= '0;
            needed_reg     <= '0;
            held_count_reg <= '0;
        end
        else if (accept)
        begin
            lead_byte_reg  <= lead_byte_next;
            needed_reg     <= needed_next;
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && needed_reg != 2'd0 && is_cont)
        begin
            held_reg[h] <= in_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/u8u16_ser.sv]
// Result register that holds one bundle and hands out its code units one by one.
`default_nettype none

module u8u16_ser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire u8u16_pkg::bundle_t  bundle,
    output logic                     free,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [15:0]              code_unit,
    output logic                     replaced,
    output logic                     run_end,
    output logic                     stream_end
);

    logic                                      valid_reg, valid_next;
    logic [1:0]                                idx_reg, idx_next;
    logic [1:0]                                last_idx_reg;
    logic                                      last_reg;
    logic [u8u16_pkg::MAX_UNITS-1:0][15:0]     unit_reg;
    logic [u8u16_pkg::MAX_UNITS-1:0]           repl_reg;
    logic                                      take;
    logic                                      fill;

    assign out_valid  = valid_reg;
    assign code_unit  = unit_reg[idx_reg];
    assign replaced   = repl_reg[idx_reg];
    assign run_end    = (idx_reg == last_idx_reg);
    assign stream_end = run_end & last_reg;
    assign take       = valid_reg & out_ready;
    assign free       = !valid_reg || (out_ready && run_end);
    assign fill       = load && (bundle.count != 3'd0);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            if (run_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (fill)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            unit_reg     <= bundle.unit;
            repl_reg     <= bundle.repl;
            last_reg     <= bundle.last;
            last_idx_reg <= 2'(bundle.count - 3'd1);
        end
    end

endmodule

`default_nettype wire

[rtl/utf8_to_utf16_validating_decoder.sv]
// Top level of the validating UTF-8 to UTF-16 decoder.
// Output: a byte's first code unit is registered and valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while out_ready is high and each byte yields at most
// one unit; a byte that yields N units (up to 4) holds the result register until all are taken.
// Reset: rst_n clears the open sequence and empties the result register.
`default_nettype none

module utf8_to_utf16_validating_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        stream_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             replaced,
    output logic             run_end,
    output logic             stream_end
);

    u8u16_pkg::bundle_t bundle;
    logic               free;
    logic               accept;

    assign in_ready = free;
    assign accept   = in_valid & free;

    u8u16_dec u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .stream_last (stream_last),
        .bundle      (bundle)
    );

    u8u16_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .bundle     (bundle),
        .free       (free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .replaced   (replaced),
        .run_end    (run_end),
        .stream_end (stream_end)
    );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the UTF-8 to UTF-16 decoder: directed table, then random streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_end;
        logic        stream_end;
    } utf16_unit_t;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        is_last;
        logic        known;
        logic [15:0] code_unit;
        logic        replaced;
    } byte_row_t;

    localparam int N_ROWS = 28;
    localparam int N_RANDOM = 350;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        stream_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_end;
    logic        stream_end;

    logic [7:0]  seq_lead = 8'h00;
    logic [1:0]  seq_need = 2'd0;
    logic [1:0]  seq_held = 2'd0;
    logic [7:0]  cont_bytes [0:2];

    utf16_unit_t step_units [$];
    utf16_unit_t pending_units [$];
    logic [7:0]  char_bytes [$];

    bit          row_known = 1'b0;
    logic [15:0] row_unit = 16'h0000;
    logic        row_repl = 1'b0;
    bit          unit_taken = 1'b1;
    int          ready_wait = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          errors = 0;
    int          random_count = 0;

    byte_row_t directed_rows [0:N_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0},
        '{8'h80, 1'b0, 1'b1, 16'hFFFD, 1'b1},
        '{8'hFF, 1'b0, 1'b1, 16'hFFFD, 1'b1},
        '{8'hC2, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hEF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hBD, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h90, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hED, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h90, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h90, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'hC3, 1'b1, 1'b1, 16'hFFFD, 1'b1}
    };

    utf8_to_utf16_validating_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .stream_last (stream_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .replaced    (replaced),
        .run_end     (run_end),
        .stream_end  (stream_end)
    );

    always #6 clk = ~clk;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic void push_unit(logic [15:0] value, logic repl);
        utf16_unit_t u;
        u = '{value, repl, 1'b0, 1'b0};
        step_units = {step_units, u};
    endfunction

    function automatic void append_byte(logic [7:0] b);
        char_bytes = {char_bytes, b};
    endfunction

    function automatic void push_scalar(logic [20:0] cp);
        logic [20:0] offset;
        offset = cp - u8u16_pkg::MIN_FOUR;
        if (cp <= 21'h00FFFF)
            push_unit(cp[15:0], 1'b0);
        else
        begin
            push_unit(u8u16_pkg::SURR_HIGH | {6'd0, offset[19:10]}, 1'b0);
            push_unit(u8u16_pkg::SURR_LOW | {6'd0, offset[9:0]}, 1'b0);
        end
    endfunction

    function automatic void flush_malformed(int held);
        for (int i = 0; i <= held; i++)
            push_unit(u8u16_pkg::REPL_CHAR, 1'b1);
        seq_need = 2'd0;
        seq_held = 2'd0;
    endfunction

    function automatic void take_lead(logic [7:0] b, logic is_last);
        logic [1:0] need;
        need = 2'd0;
        if (b <= 8'h7F)
            push_unit({8'h00, b}, 1'b0);
        else
        begin
            if (b[7:5] == 3'b110)
                need = 2'd1;
            else if (b[7:4] == 4'b1110)
                need = 2'd2;
            else if (b[7:3] == 5'b11110)
                need = 2'd3;
            if (need == 2'd0 || is_last)
                push_unit(u8u16_pkg::REPL_CHAR, 1'b1);
            else
            begin
                seq_lead = b;
                seq_need = need;
                seq_held = 2'd0;
            end
        end
    endfunction

    function automatic void close_sequence();
        logic [20:0] cp;
        logic        ok;
        logic [5:0]  c0;
        logic [5:0]  c1;
        logic [5:0]  c2;
        c0 = cont_bytes[0][5:0];
        c1 = cont_bytes[1][5:0];
        c2 = cont_bytes[2][5:0];
        case (seq_need)
            2'd1:
            begin
                cp = {10'd0, seq_lead[4:0], c0};
                ok = cp >= u8u16_pkg::MIN_TWO;
            end
            2'd2:
            begin
                cp = {5'd0, seq_lead[3:0], c0, c1};
                ok = cp >= u8u16_pkg::MIN_THREE
                     && !(cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST);
            end
            default:
            begin
                cp = {seq_lead[2:0], c0, c1, c2};
                ok = cp >= u8u16_pkg::MIN_FOUR && cp <= u8u16_pkg::MAX_SCALAR;
            end
        endcase
        if (!ok)
            flush_malformed(int'(seq_need));
        else
        begin
            seq_need = 2'd0;
            seq_held = 2'd0;
            push_scalar(cp);
        end
    endfunction

    function automatic void advance_decoder(logic [7:0] b, logic is_last);
        int slot;
        if (seq_need != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                slot = (seq_held > 2'd2) ? 2 : int'(seq_held);
                cont_bytes[slot] = b;
                seq_held = 2'(slot + 1);
                if (seq_held >= seq_need)
                    close_sequence();
                else if (is_last)
                    flush_malformed(int'(seq_held));
            end
            else
            begin
                flush_malformed(int'(seq_held));
                take_lead(b, is_last);
            end
        end
        else
            take_lead(b, is_last);
    endfunction

    function automatic void predict_units(logic [7:0] b, logic is_last);
        utf16_unit_t tail;
        step_units.delete();
        advance_decoder(b, is_last);
        if (row_known)
        begin
            step_units.delete();
            push_unit(row_unit, row_repl);
        end
        if (step_units.size() > 0)
        begin
            tail = step_units.pop_back();
            tail.run_end = 1'b1;
            tail.stream_end = is_last;
            step_units = {step_units, tail};
        end
        pending_units = {pending_units, step_units};
    endfunction

    function automatic void check_unit();
        utf16_unit_t want;
        if (pending_units.size() == 0)
        begin
            $error("unexpected code unit %h", code_unit);
            errors++;
        end
        else
        begin
            want = pending_units.pop_front();
            if (code_unit !== want.code_unit)
            begin
                $error("code_unit: expected %h, got %h", want.code_unit, code_unit);
                errors++;
            end
            if (replaced !== want.replaced)
            begin
                $error("replaced: expected %b, got %b", want.replaced, replaced);
                errors++;
            end
            if (run_end !== want.run_end)
            begin
                $error("run_end: expected %b, got %b", want.run_end, run_end);
                errors++;
            end
            if (stream_end !== want.stream_end)
            begin
                $error("stream_end: expected %b, got %b", want.stream_end, stream_end);
                errors++;
            end
        end
    endfunction

    function automatic void build_char();
        logic [20:0] cp;
        int          kind;
        int          n_cont;
        char_bytes.delete();
        kind = int'($urandom_range(0, 15));
        if (kind <= 3)
            append_byte(8'($urandom_range(0, 127)));
        else if (kind <= 6)
        begin
            cp = 21'($urandom_range(32'h80, 32'h7FF));
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else if (kind <= 9)
        begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else if (kind <= 11)
        begin
            cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else if (kind == 12)
            append_byte(8'($urandom_range(0, 255)));
        else
        begin
            append_byte(8'($urandom_range(32'hC0, 32'hF7)));
            n_cont = int'($urandom_range(0, 3));
            for (int i = 0; i < n_cont; i++)
                append_byte({2'b10, 6'($urandom_range(0, 63))});
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic is_last, bit known, logic [15:0] unit,
                             logic repl);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        stream_last <= is_last;
        row_known = known;
        row_unit = unit;
        row_repl = repl;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_units.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_units(in_byte, stream_last);
            if (out_valid && out_ready)
            begin
                unit_taken = 1'b1;
                check_unit();
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (unit_taken)
            begin
                unit_taken = 1'b0;
                ready_wait = draw_gap(rx_calm);
            end
            out_ready <= (ready_wait == 0);
            if (ready_wait > 0)
                ready_wait--;
        end
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_byte(directed_rows[r].in_byte, directed_rows[r].is_last,
                      directed_rows[r].known, directed_rows[r].code_unit,
                      directed_rows[r].replaced);
        hold_until_drained();

        while (random_count < N_RANDOM)
        begin
            build_char();
            foreach (char_bytes[i])
            begin
                send_byte(char_bytes[i], $urandom_range(0, 24) == 0, 1'b0, 16'h0000, 1'b0);
                random_count++;
                if (random_count == N_RANDOM / 2)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (pending_units.size() != 0)
        begin
            $error("%0d code units never arrived", pending_units.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/u8u16_pkg.sv
rtl/u8u16_dec.sv
rtl/u8u16_ser.sv
rtl/utf8_to_utf16_validating_decoder.sv
bench/tb_top.sv
